// ----- rtl/core/spa_pkg.sv -----
// Shared types, codes and helpers for the slot pool allocator.
// Used by the top level and its checker.
// Depends on nothing.
package spa_pkg;

   // Used-map memory word and the bit index inside it
   localparam int MAP_WORD_W = 32;
   localparam int MAP_BIT_W  = 5;

   typedef enum logic [1:0] {
      ACT_ALLOC = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_FULL     = 2'd1,
      STS_BAD_FREE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HINT,
      ST_HCHK,
      ST_SCAN,
      ST_GRANT,
      ST_NEXT,
      ST_FREE,
      ST_RESP
   } state_type;

   // Lowest clear bit of a map word
   function automatic logic [MAP_BIT_W-1:0] first_zero(input logic [MAP_WORD_W-1:0] w);
      logic [MAP_BIT_W-1:0] idx;
      idx = '0;
      for (int i = MAP_WORD_W - 1; i >= 0; i--) begin
         if (!w[i]) idx = MAP_BIT_W'(i);
      end
      return idx;
   endfunction

endpackage

// ----- rtl/core/slot_pool_allocator_top.sv -----
// Slot pool allocator: used-bit map and free-slot hint stack in on-chip memories.
// Depends on spa_pkg (codes, state type, map word helpers).
//
//   channel | dir | handshake              | word
//   --------+-----+------------------------+------------------------------------------
//   req     | in  | req_valid / req_stall  | req_action, req_slot_index
//   rsp     | out | rsp_valid / rsp_stall  | rsp_granted_slot, rsp_status, rsp_used_count
//   csr     | in  | csr_valid / csr_ready  | csr_wdata (capacity)
//
// A scan allocate visits up to ceil(capacity/32) 32-slot map words. The used map has one
// read port with registered read data. Reset and every capacity write clear the map one
// word per cycle (ceil(SLOTS/32) words) with req_stall high. A result waits in the output
// register while the next word is taken; only the following result waits for rsp_stall
// to drop.
module slot_pool_allocator_top
   import spa_pkg::*;
#(
   parameter int SLOTS      = 256,
   parameter int HINT_DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_action,
   input  logic [$clog2(SLOTS+1)-1:0]       req_slot_index,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [$clog2(SLOTS+1)-1:0]       rsp_granted_slot,
   output logic [1:0]                       rsp_status,
   output logic [$clog2(SLOTS+1)-1:0]       rsp_used_count,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [$clog2(SLOTS+1)-1:0]       csr_wdata
);

   localparam int SLOT_W  = $clog2(SLOTS + 1);
   localparam int NW      = (SLOTS + MAP_WORD_W - 1) / MAP_WORD_W;
   localparam int WADDR_W = (NW > 1) ? $clog2(NW) : 1;
   localparam int POS_W   = MAP_BIT_W + WADDR_W;
   localparam int CNT_W   = $clog2(HINT_DEPTH + 1);
   localparam int SIDX_W  = (HINT_DEPTH > 1) ? $clog2(HINT_DEPTH) : 1;
   localparam int CMP_W   = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;

   localparam logic [SLOT_W-1:0]     SLOT_MAX  = SLOT_W'(SLOTS);
   localparam logic [SLOT_W-1:0]     SLOT_ONE  = SLOT_W'(1);
   localparam logic [CNT_W-1:0]      HINT_MAX  = CNT_W'(HINT_DEPTH);
   localparam logic [CNT_W-1:0]      CNT_ONE   = CNT_W'(1);
   localparam logic [WADDR_W-1:0]    LAST_WORD = WADDR_W'(NW - 1);
   localparam logic [WADDR_W-1:0]    WORD_ONE  = WADDR_W'(1);
   localparam logic [MAP_WORD_W-1:0] BIT_ONE   = MAP_WORD_W'(1);

   // ---------------------------------------------------------------- state
   state_type               state_ff, state_in;
   logic [SLOT_W-1:0]       cap_ff, cap_in;        // effective capacity, 1..SLOTS
   logic [CNT_W-1:0]        fill_ff, fill_in;      // min(capacity, HINT_DEPTH) at last clear
   logic [CNT_W-1:0]        cnt_ff, cnt_in;        // hint stack fill
   logic [CNT_W-1:0]        prist_ff, prist_in;    // entries below this still hold fill - k
   logic [SLOT_W-1:0]       inuse_ff, inuse_in;
   logic [WADDR_W-1:0]      clr_ptr_ff, clr_ptr_in;
   logic                    clr_resp_ff, clr_resp_in;
   logic [WADDR_W-1:0]      scan_ff, scan_in;
   logic [WADDR_W-1:0]      waddr_ff, waddr_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [MAP_WORD_W-1:0]   word_ff, word_in;
   logic [SIDX_W-1:0]       hidx_ff, hidx_in;
   logic [SLOT_W-1:0]       res_slot_ff, res_slot_in;
   status_type              res_status_ff, res_status_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]       rsp_slot_ff, rsp_slot_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]       rsp_count_ff, rsp_count_in;

   // ---------------------------------------------------------------- memories
   logic [MAP_WORD_W-1:0]   map_mem [NW];
   logic [MAP_WORD_W-1:0]   map_rd_ff;
   logic                    map_we;
   logic [WADDR_W-1:0]      map_waddr, map_raddr;
   logic [MAP_WORD_W-1:0]   map_wdata;

   logic [SLOT_W-1:0]       stk_mem [HINT_DEPTH];
   logic [SLOT_W-1:0]       stk_rd_ff;
   logic                    stk_we;
   logic [SIDX_W-1:0]       stk_waddr, stk_raddr;
   logic [SLOT_W-1:0]       stk_wdata;

   // ---------------------------------------------------------------- decode
   logic                    in_idle, csr_take, req_take, out_free, has_room;
   action_type              req_act;
   logic [SLOT_W-1:0]       csr_cap;
   logic [CNT_W-1:0]        fill_new;
   logic                    req_free_ok;
   logic [POS_W-1:0]        req_pos, slot_pos, hint_pos, next_pos, scan_pos;
   logic [CMP_W-1:0]        hint_wide;
   logic [SLOT_W-1:0]       hint_val, scan_slot;
   logic                    hint_ok, hchk_free, scan_found, free_ok;
   logic                    next_chk, next_same;
   logic [MAP_BIT_W-1:0]    scan_bit;
   logic [CNT_W-1:0]        hidx_wide;

   assign in_idle   = (state_ff == ST_IDLE);
   assign csr_ready = in_idle;
   // Hold off requests while a capacity write is offered
   assign req_stall = !in_idle || csr_valid;
   assign csr_take  = csr_valid && in_idle;
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign has_room  = (inuse_ff < cap_ff);
   assign req_act   = action_type'(req_action);

   always_comb begin
      // Saturate capacity to 1..SLOTS
      if (csr_wdata == '0) begin
         csr_cap = SLOT_ONE;
      end else if (csr_wdata > SLOT_MAX) begin
         csr_cap = SLOT_MAX;
      end else begin
         csr_cap = csr_wdata;
      end
      if (CMP_W'(cap_ff) < CMP_W'(HINT_DEPTH)) begin
         fill_new = CNT_W'(cap_ff);
      end else begin
         fill_new = HINT_MAX;
      end
   end

   always_comb begin
      req_free_ok = (req_slot_index != '0) && (req_slot_index <= cap_ff);
      req_pos     = POS_W'(req_slot_index - SLOT_ONE);
      slot_pos    = POS_W'(slot_ff - SLOT_ONE);
      // Untouched stack entries still read as fill - k
      hidx_wide   = CNT_W'(hidx_ff);
      hint_wide   = CMP_W'(fill_ff) - CMP_W'(hidx_ff);
      hint_val    = (hidx_wide < prist_ff) ? SLOT_W'(hint_wide) : stk_rd_ff;
      hint_ok     = (hint_val != '0) && (hint_val <= cap_ff);
      hint_pos    = POS_W'(hint_val - SLOT_ONE);
      hchk_free   = !map_rd_ff[slot_pos[MAP_BIT_W-1:0]];
      scan_found  = (map_rd_ff != '1);
      scan_bit    = first_zero(map_rd_ff);
      scan_pos    = {scan_ff, scan_bit};
      scan_slot   = SLOT_W'(scan_pos) + SLOT_ONE;
      free_ok     = map_rd_ff[slot_pos[MAP_BIT_W-1:0]] && (inuse_ff != '0);
      // Zero-based position of the slot just above the grant
      next_pos    = POS_W'(slot_ff);
      next_chk    = (cnt_ff == '0) && (slot_ff < cap_ff);
      next_same   = (next_pos[POS_W-1:MAP_BIT_W] == waddr_ff);
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ptr_ff == LAST_WORD) state_in = clr_resp_ff ? ST_RESP : ST_IDLE;
         end
         ST_IDLE: begin
            if (csr_take) begin
               state_in = ST_CLEAR;
            end else if (req_take) begin
               case (req_act)
                  ACT_ALLOC: begin
                     if (cnt_ff != '0)  state_in = ST_HINT;
                     else if (has_room) state_in = ST_SCAN;
                     else               state_in = ST_RESP;
                  end
                  ACT_FREE:  state_in = req_free_ok ? ST_FREE : ST_RESP;
                  ACT_CLEAR: state_in = ST_CLEAR;
                  default:   state_in = ST_RESP;
               endcase
            end
         end
         ST_HINT: begin
            if (hint_ok)       state_in = ST_HCHK;
            else if (has_room) state_in = ST_SCAN;
            else               state_in = ST_RESP;
         end
         ST_HCHK: begin
            if (hchk_free)     state_in = ST_GRANT;
            else if (has_room) state_in = ST_SCAN;
            else               state_in = ST_RESP;
         end
         ST_SCAN: begin
            if (scan_found) state_in = ST_GRANT;
         end
         ST_GRANT: begin
            state_in = (next_chk && !next_same) ? ST_NEXT : ST_RESP;
         end
         ST_NEXT:  state_in = ST_RESP;
         ST_FREE:  state_in = ST_RESP;
         ST_RESP: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath and memory control
   always_comb begin
      cap_in        = cap_ff;
      fill_in       = fill_ff;
      cnt_in        = cnt_ff;
      prist_in      = prist_ff;
      inuse_in      = inuse_ff;
      clr_ptr_in    = clr_ptr_ff;
      clr_resp_in   = clr_resp_ff;
      scan_in       = scan_ff;
      waddr_in      = waddr_ff;
      slot_in       = slot_ff;
      word_in       = word_ff;
      hidx_in       = hidx_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      map_we        = 1'b0;
      map_waddr     = '0;
      map_wdata     = '0;
      map_raddr     = '0;
      stk_we        = 1'b0;
      stk_waddr     = '0;
      stk_wdata     = '0;
      stk_raddr     = '0;

      case (state_ff)
         ST_CLEAR: begin
            // Sweep the used map, one word per cycle
            map_we     = 1'b1;
            map_waddr  = clr_ptr_ff;
            clr_ptr_in = clr_ptr_ff + WORD_ONE;
            if (clr_ptr_ff == LAST_WORD) begin
               fill_in       = fill_new;
               cnt_in        = fill_new;
               prist_in      = fill_new;
               inuse_in      = '0;
               res_slot_in   = '0;
               res_status_in = STS_OK;
            end
         end
         ST_IDLE: begin
            if (csr_take) begin
               cap_in      = csr_cap;
               clr_ptr_in  = '0;
               clr_resp_in = 1'b0;
            end else if (req_take) begin
               res_slot_in   = '0;
               res_status_in = STS_OK;
               case (req_act)
                  ACT_ALLOC: begin
                     if (cnt_ff != '0) begin
                        // Pop the hint stack: the count drops even if the hint is stale
                        cnt_in    = cnt_ff - CNT_ONE;
                        hidx_in   = SIDX_W'(cnt_ff - CNT_ONE);
                        stk_raddr = SIDX_W'(cnt_ff - CNT_ONE);
                     end else if (has_room) begin
                        scan_in   = '0;
                        map_raddr = '0;
                     end else begin
                        res_status_in = STS_FULL;
                     end
                  end
                  ACT_FREE: begin
                     slot_in   = req_slot_index;
                     waddr_in  = req_pos[POS_W-1:MAP_BIT_W];
                     map_raddr = req_pos[POS_W-1:MAP_BIT_W];
                     if (!req_free_ok) res_status_in = STS_BAD_FREE;
                  end
                  ACT_CLEAR: begin
                     clr_ptr_in  = '0;
                     clr_resp_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_HINT: begin
            if (hint_ok) begin
               slot_in   = hint_val;
               waddr_in  = hint_pos[POS_W-1:MAP_BIT_W];
               map_raddr = hint_pos[POS_W-1:MAP_BIT_W];
            end else if (has_room) begin
               scan_in   = '0;
               map_raddr = '0;
            end else begin
               res_status_in = STS_FULL;
            end
         end
         ST_HCHK: begin
            if (hchk_free) begin
               word_in = map_rd_ff | (BIT_ONE << slot_pos[MAP_BIT_W-1:0]);
            end else if (has_room) begin
               scan_in   = '0;
               map_raddr = '0;
            end else begin
               res_status_in = STS_FULL;
            end
         end
         ST_SCAN: begin
            if (scan_found) begin
               word_in  = map_rd_ff | (BIT_ONE << scan_bit);
               waddr_in = scan_ff;
               slot_in  = scan_slot;
            end else begin
               // Advance to the next word; its data arrives next cycle
               scan_in   = scan_ff + WORD_ONE;
               map_raddr = scan_ff + WORD_ONE;
            end
         end
         ST_GRANT: begin
            map_we        = 1'b1;
            map_waddr     = waddr_ff;
            map_wdata     = word_ff;
            inuse_in      = inuse_ff + SLOT_ONE;
            res_slot_in   = slot_ff;
            res_status_in = STS_OK;
            if (next_chk) begin
               if (next_same) begin
                  if (!word_ff[next_pos[MAP_BIT_W-1:0]]) begin
                     stk_we    = 1'b1;
                     stk_waddr = '0;
                     stk_wdata = slot_ff + SLOT_ONE;
                     cnt_in    = CNT_ONE;
                     prist_in  = '0;
                  end
               end else begin
                  map_raddr = next_pos[POS_W-1:MAP_BIT_W];
               end
            end
         end
         ST_NEXT: begin
            // Next slot opens a new word: its bit 0
            if (!map_rd_ff[0]) begin
               stk_we    = 1'b1;
               stk_waddr = '0;
               stk_wdata = slot_ff + SLOT_ONE;
               cnt_in    = CNT_ONE;
               prist_in  = '0;
            end
         end
         ST_FREE: begin
            if (free_ok) begin
               map_we    = 1'b1;
               map_waddr = waddr_ff;
               map_wdata = map_rd_ff & ~(BIT_ONE << slot_pos[MAP_BIT_W-1:0]);
               inuse_in  = inuse_ff - SLOT_ONE;
               if (cnt_ff < HINT_MAX) begin
                  stk_we    = 1'b1;
                  stk_waddr = cnt_ff[SIDX_W-1:0];
                  stk_wdata = slot_ff;
                  cnt_in    = cnt_ff + CNT_ONE;
                  prist_in  = (prist_ff < cnt_ff) ? prist_ff : cnt_ff;
               end
            end else begin
               res_status_in = STS_BAD_FREE;
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- output register
   always_comb begin
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (state_ff == ST_RESP && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_slot_in   = res_slot_ff;
         rsp_status_in = res_status_ff;
         rsp_count_in  = inuse_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_slot = rsp_slot_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_used_count   = rsp_count_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cap_ff       <= SLOT_MAX;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         prist_ff     <= '0;
         inuse_ff     <= '0;
         clr_ptr_ff   <= '0;
         clr_resp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         prist_ff     <= prist_in;
         inuse_ff     <= inuse_in;
         clr_ptr_ff   <= clr_ptr_in;
         clr_resp_ff  <= clr_resp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      waddr_ff      <= waddr_in;
      slot_ff       <= slot_in;
      word_ff       <= word_in;
      hidx_ff       <= hidx_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Used map: one write and one read port, read data registered
   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_waddr] <= map_wdata;
      map_rd_ff <= map_mem[map_raddr];
   end

   // Hint stack: same shape
   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
      stk_rd_ff <= stk_mem[stk_raddr];
   end

endmodule

// ----- rtl/core/spa_chk.sv -----
// Port-level checker for the slot pool allocator, bound to the top level.
// Depends on spa_pkg (status codes) and slot_pool_allocator_top.
module spa_chk
   import spa_pkg::*;
#(
   parameter int SLOTS = 256
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [$clog2(SLOTS+1)-1:0]   rsp_granted_slot,
   input logic [1:0]                   rsp_status,
   input logic [$clog2(SLOTS+1)-1:0]   rsp_used_count
);

   // A failed request never carries a slot
   a_fail_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STS_OK) |-> (rsp_granted_slot == '0))
      else $error("non-ok result carries a granted slot");

   // A granted slot is counted as in use
   a_grant_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_granted_slot != '0) |-> (rsp_used_count != '0))
      else $error("grant reported with zero slots in use");

   // Full only when at least one slot is in use
   a_full_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STS_FULL) |-> (rsp_used_count != '0))
      else $error("pool full reported with an empty pool");

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_granted_slot)
         && $stable(rsp_status) && $stable(rsp_used_count))
      else $error("stalled result word changed");

endmodule

bind slot_pool_allocator_top spa_chk #(.SLOTS(SLOTS)) u_spa_chk (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_granted_slot (rsp_granted_slot),
   .rsp_status       (rsp_status),
   .rsp_used_count   (rsp_used_count)
);
